// File: rtl/core/xsfb_pkg.sv
package xsfb_pkg;

    localparam int FRAME_ROWS_DEF = 32;
    localparam int FRAME_COLS_DEF = 64;
    localparam int ROW_BITS_W     = 64;
    localparam int SPRITE_W       = 8;
    localparam int COORD_W        = 8;
    localparam int TAB_DEPTH      = 256;
    localparam int TAB_W          = 6;

    typedef enum logic [1:0] {
        FUNC_DRAW  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef logic [TAB_W-1:0] mod_tab_t [TAB_DEPTH];

    // value mod modulus for every 8-bit value, built by counting
    function automatic mod_tab_t mod_table(input int modulus);
        mod_tab_t tab;
        int       m;
        m = 0;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            tab[i] = TAB_W'(m);
            m = m + 1;
            if (m == modulus)
            begin
                m = 0;
            end
        end
        return tab;
    endfunction

endpackage

// File: rtl/core/xor_sprite_framebuffer_core.sv
// One-bit frame store with XOR sprite drawing and collision detection.
// Input channel (item_valid / item_stall): func selects draw of one sprite
// row, clear of the whole frame, or read of one frame row. A transfer
// happens when item_valid is high and item_stall is low.
// Result channel (result_valid / result_stall): exactly one result per
// item: collision and sprite_done for a draw, row_bits for a read, all
// zero otherwise.
// The frame memory is read at the input transfer edge; the modify, the
// write back and the registered result follow at the end of the ST_RUN
// state. No new item is taken before the last one leaves ST_RUN, as set
// by the single read-modify-write of the frame memory per item.
// A result waiting on result_stall does not block the next input transfer;
// that item is then held in its write-back cycle until the waiting result
// is transferred.
// Reset: all rows read as blank (per-row valid bits cleared), collision
// accumulator cleared, no result pending. A clear item also drops all valid
// bits at once, so there is no clearing sweep.
module xor_sprite_framebuffer_core #(
    parameter int FRAME_ROWS = xsfb_pkg::FRAME_ROWS_DEF,
    parameter int FRAME_COLS = xsfb_pkg::FRAME_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      func,
    input  logic [xsfb_pkg::COORD_W-1:0]    start_x,
    input  logic [xsfb_pkg::COORD_W-1:0]    start_y,
    input  logic [3:0]                      row_index,
    input  logic [xsfb_pkg::SPRITE_W-1:0]   sprite_byte,
    input  logic                            last_row,
    input  logic [4:0]                      read_row,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            collision,
    output logic                            sprite_done,
    output logic [xsfb_pkg::ROW_BITS_W-1:0] row_bits
);
    import xsfb_pkg::*;

    localparam int ROW_W = $clog2(FRAME_ROWS);
    localparam int RS_W  = ROW_W + 1;
    localparam int COL_W = $clog2(FRAME_COLS);
    localparam int CS_W  = COL_W + 1;

    localparam mod_tab_t ROW_TAB = mod_table(FRAME_ROWS);
    localparam mod_tab_t COL_TAB = mod_table(FRAME_COLS);

    logic [FRAME_COLS-1:0] frame_mem [FRAME_ROWS];

    state_t                state_reg, state_next;
    logic [FRAME_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                  entry_valid_reg;
    logic [FRAME_COLS-1:0] rd_data_reg;
    logic [FRAME_COLS-1:0] mask_reg;
    logic [ROW_W-1:0]      addr_reg;
    logic [1:0]            func_reg;
    logic                  first_row_reg;
    logic                  last_row_reg;
    logic                  coll_acc_reg, coll_acc_next;
    logic                  result_valid_reg, result_valid_next;
    logic                  collision_reg, collision_next;
    logic                  sprite_done_reg, sprite_done_next;
    logic [ROW_BITS_W-1:0] row_bits_reg, row_bits_next;

    logic                  item_accept;
    logic                  finish;
    logic                  wr_en;
    logic [FRAME_COLS-1:0] old_row;
    logic [FRAME_COLS-1:0] new_row;
    logic [ROW_W-1:0]      y_mod;
    logic [RS_W-1:0]       ri_mod;
    logic [RS_W-1:0]       y_sum;
    logic [ROW_W-1:0]      draw_addr;
    logic [ROW_W-1:0]      read_addr;
    logic [ROW_W-1:0]      rd_addr;
    logic [COL_W-1:0]      x_mod;
    logic [CS_W-1:0]       col_sum;
    logic [COL_W-1:0]      col;
    logic [FRAME_COLS-1:0] mask;

    // row address
    always_comb
    begin
        y_mod  = ROW_W'(ROW_TAB[start_y]);
        ri_mod = RS_W'(row_index);
        if (ri_mod >= RS_W'(FRAME_ROWS))
        begin
            ri_mod = ri_mod - RS_W'(FRAME_ROWS);
        end
        y_sum = RS_W'(y_mod) + ri_mod;
        if (y_sum >= RS_W'(FRAME_ROWS))
        begin
            y_sum = y_sum - RS_W'(FRAME_ROWS);
        end
        draw_addr = y_sum[ROW_W-1:0];
        read_addr = ROW_W'(ROW_TAB[{3'b000, read_row}]);
        rd_addr   = (func_t'(func) == FUNC_READ) ? read_addr : draw_addr;
    end

    // sprite mask, MSB leftmost
    always_comb
    begin
        x_mod   = COL_W'(COL_TAB[start_x]);
        mask    = '0;
        col_sum = '0;
        col     = '0;
        for (int b = 0; b < SPRITE_W; b++)
        begin
            col_sum = CS_W'(x_mod) + CS_W'(SPRITE_W - 1 - b);
            if (col_sum >= CS_W'(FRAME_COLS))
            begin
                col_sum = col_sum - CS_W'(FRAME_COLS);
            end
            col       = col_sum[COL_W-1:0];
            mask[col] = mask[col] | sprite_byte[b];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        item_stall = 1'b1;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_RUN:
            begin
                finish = !(result_valid_reg && result_stall);
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign item_accept = item_valid && !item_stall;
    assign old_row     = entry_valid_reg ? rd_data_reg : '0;
    assign new_row     = old_row ^ mask_reg;
    assign wr_en       = finish && (func_reg == FUNC_DRAW);

    // write-back and result
    always_comb
    begin
        row_valid_next    = row_valid_reg;
        coll_acc_next     = coll_acc_reg;
        result_valid_next = result_valid_reg && result_stall;
        collision_next    = collision_reg;
        sprite_done_next  = sprite_done_reg;
        row_bits_next     = row_bits_reg;
        if (finish)
        begin
            result_valid_next = 1'b1;
            collision_next    = 1'b0;
            sprite_done_next  = 1'b0;
            row_bits_next     = '0;
            case (func_reg)
                FUNC_DRAW:
                begin
                    coll_acc_next = (coll_acc_reg && !first_row_reg) ||
                                    ((old_row & mask_reg) != '0);
                    row_valid_next[addr_reg] = 1'b1;
                    collision_next   = coll_acc_next;
                    sprite_done_next = last_row_reg;
                end
                FUNC_CLEAR:
                begin
                    row_valid_next = '0;
                end
                FUNC_READ:
                begin
                    row_bits_next = ROW_BITS_W'(old_row);
                end
                default:
                begin
                    row_bits_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_valid_reg    <= '0;
            coll_acc_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_valid_reg    <= row_valid_next;
            coll_acc_reg     <= coll_acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        collision_reg   <= collision_next;
        sprite_done_reg <= sprite_done_next;
        row_bits_reg    <= row_bits_next;
        if (item_accept)
        begin
            entry_valid_reg <= row_valid_reg[rd_addr];
            mask_reg        <= mask;
            addr_reg        <= rd_addr;
            first_row_reg   <= (row_index == 4'd0);
            last_row_reg    <= last_row;
            func_reg        <= func;
        end
    end

    // frame memory, registered read
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
        if (wr_en)
        begin
            frame_mem[addr_reg] <= new_row;
        end
    end

    assign result_valid = result_valid_reg;
    assign collision    = collision_reg;
    assign sprite_done  = sprite_done_reg;
    assign row_bits     = row_bits_reg;

endmodule
